### rtl/core/char_lcd_line_refresher_unit_assert.svh
// Assertion macros shared by the character LCD refresher RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef CHAR_LCD_LINE_REFRESHER_UNIT_ASSERT_SVH
`define CHAR_LCD_LINE_REFRESHER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define CLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define CLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/clr_pkg.sv
// Shared types and constants for the character LCD line refresher.
// No dependencies.
package clr_pkg;

  localparam int unsigned CLR_COLUMNS = 20;

  localparam logic [7:0] CLR_LINE0_ADDR = 8'h80;
  localparam logic [7:0] CLR_LINE1_ADDR = 8'hC0;
  localparam logic [5:0] CLR_COL_MASK   = 6'h3F;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_REFRESH  = 2'd1,
    CMD_POSITION = 2'd2,
    CMD_INSTR    = 2'd3
  } clr_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_ADDR,
    ST_DAT_RD,
    ST_DAT_OUT
  } clr_state_e;

  // Per-port control of one frame store.
  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] wdata;
  } clr_ram_ctl_t;

endpackage

### rtl/core/char_lcd_line_refresher_unit.sv
// Character LCD line refresher, top level: sequencer and output register.
// Depends on clr_pkg, clr_frame_ram and char_lcd_line_refresher_unit_assert.svh.
//
// Usage:
//  - Slave stream: one transaction per command. tuser carries the command
//    (write char, refresh, set position, raw instruction).
//  - Master stream: one transaction per LCD byte, split into high and low
//    nibble; tuser is register select, tlast marks the final byte of a command.
//  - Write char: no output. Position / instruction: one byte,
//    valid the cycle after acceptance.
//  - Refresh: a compare pass over all 2*COLUMNS entries, each entry read
//    (ST_CMP_RD, registered frame store read) and then compared (ST_CMP_CHK);
//    then per changed line one address byte and COLUMNS data bytes, each
//    data byte read from the pending frame (ST_DAT_RD) and then sent
//    (ST_DAT_OUT).
//  - The block takes one command at a time; s_axis_tready is low while a
//    refresh runs and while the output register holds a byte the sink has
//    not taken.
//  - A sink stall freezes the sequencer; nothing is dropped.
//  - Reset: both frames read as all zero, sequencer idle, output empty.
`include "char_lcd_line_refresher_unit_assert.svh"

module char_lcd_line_refresher_unit #(
  parameter int unsigned COLUMNS = clr_pkg::CLR_COLUMNS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [0] line, [6:1] column, [14:7] byte_value, [15] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] high_nibble, [7:4] low_nibble
  output logic        m_axis_tuser,   // [0] register_select
  output logic        m_axis_tlast
);
  import clr_pkg::*;

  localparam int unsigned DEPTH = 2 * COLUMNS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW-1:0] LINE1_IDX = AW'(COLUMNS);
  localparam logic [AW-1:0] LINE0_END = AW'(COLUMNS - 1);

  clr_state_e    state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          dif0_q, dif0_d;
  logic          dif1_q, dif1_d;
  logic          out_vld_q, out_vld_d;
  logic          out_rs_q, out_rs_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;

  clr_ram_ctl_t  pend_ctl, shown_ctl;
  logic [7:0]    pend_rdata, shown_rdata;

  // Input unpacking
  clr_cmd_e      in_cmd;
  logic          in_line;
  logic [5:0]    in_column;
  logic [7:0]    in_byte;
  logic          accept;
  logic          out_free;
  logic          col_ok;
  logic [7:0]    wr_sum;
  logic [AW-1:0] wr_addr;

  // Sequencer helpers
  logic          idx_line;
  logic          line_end;
  logic          mism;
  logic          dif0_n, dif1_n;

  assign in_cmd    = clr_cmd_e'(s_axis_tuser);
  assign in_line   = s_axis_tdata[0];
  assign in_column = s_axis_tdata[6:1];
  assign in_byte   = s_axis_tdata[14:7];

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Entry = line*COLUMNS + column; only used when the column is in range.
  assign col_ok  = {1'b0, in_column} < 7'(COLUMNS);
  assign wr_sum  = {2'b00, in_column} + (in_line ? 8'(COLUMNS) : 8'd0);
  assign wr_addr = wr_sum[AW-1:0];

  assign idx_line = idx_q >= LINE1_IDX;
  assign line_end = (idx_q == LINE0_END) || (idx_q == LAST_IDX);
  assign mism     = pend_rdata != shown_rdata;
  assign dif0_n   = dif0_q || (mism && !idx_line);
  assign dif1_n   = dif1_q || (mism && idx_line);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      dif0_q    <= 1'b0;
      dif1_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      dif0_q    <= dif0_d;
      dif1_q    <= dif1_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rs_q   <= out_rs_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    dif0_d     = dif0_q;
    dif1_d     = dif1_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_rs_d   = out_rs_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    pend_ctl   = '0;
    shown_ctl  = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_WRITE: begin
              pend_ctl.we    = col_ok;
              pend_ctl.wdata = in_byte;
            end
            CMD_REFRESH: begin
              idx_d   = '0;
              dif0_d  = 1'b0;
              dif1_d  = 1'b0;
              state_d = ST_CMP_RD;
            end
            CMD_POSITION: begin
              out_vld_d  = 1'b1;
              out_rs_d   = 1'b0;
              out_byte_d = (in_line ? CLR_LINE1_ADDR : CLR_LINE0_ADDR)
                           | {2'b00, in_column & CLR_COL_MASK};
              out_last_d = 1'b1;
            end
            CMD_INSTR: begin
              out_vld_d  = 1'b1;
              out_rs_d   = 1'b0;
              out_byte_d = in_byte;
              out_last_d = 1'b1;
            end
            default: ;
          endcase
        end
      end

      ST_CMP_RD: begin
        pend_ctl.re  = 1'b1;
        shown_ctl.re = 1'b1;
        state_d      = ST_CMP_CHK;
      end

      ST_CMP_CHK: begin
        dif0_d = dif0_n;
        dif1_d = dif1_n;
        if (idx_q == LAST_IDX) begin
          if (dif0_n) begin
            idx_d   = '0;
            state_d = ST_ADDR;
          end else if (dif1_n) begin
            idx_d   = LINE1_IDX;
            state_d = ST_ADDR;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CMP_RD;
        end
      end

      ST_ADDR: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_rs_d   = 1'b0;
          out_byte_d = idx_line ? CLR_LINE1_ADDR : CLR_LINE0_ADDR;
          out_last_d = 1'b0;
          state_d    = ST_DAT_RD;
        end
      end

      ST_DAT_RD: begin
        pend_ctl.re = 1'b1;
        state_d     = ST_DAT_OUT;
      end

      ST_DAT_OUT: begin
        if (out_free) begin
          out_vld_d       = 1'b1;
          out_rs_d        = 1'b1;
          out_byte_d      = pend_rdata;
          // Line 0's final byte ends the item only if line 1 is unchanged.
          out_last_d      = line_end && (idx_line || !dif1_q);
          shown_ctl.we    = 1'b1;
          shown_ctl.wdata = pend_rdata;
          if (line_end) begin
            if (!idx_line && dif1_q) begin
              idx_d   = LINE1_IDX;
              state_d = ST_ADDR;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_DAT_RD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  clr_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (pend_ctl),
    .waddr_i (wr_addr),
    .raddr_i (idx_q),
    .rdata_o (pend_rdata)
  );

  clr_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_shown_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (shown_ctl),
    .waddr_i (idx_q),
    .raddr_i (idx_q),
    .rdata_o (shown_rdata)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_byte_q[3:0], out_byte_q[7:4]};
  assign m_axis_tuser  = out_rs_q;
  assign m_axis_tlast  = out_last_q;

  `CLR_ASSERT_NOW(a_busy_not_ready, state_q != ST_IDLE, !s_axis_tready, "ready while busy")
  `CLR_ASSERT_NOW(a_idx_range, 1'b1, idx_q <= LAST_IDX, "frame index out of range")
  `CLR_ASSERT_NEXT(a_addr_byte, (state_q == ST_ADDR) && out_free,
                   !m_axis_tuser && !m_axis_tlast, "address byte flagged as data or last")
  `CLR_ASSERT_NEXT(a_data_byte, (state_q == ST_DAT_OUT) && out_free,
                   m_axis_tvalid && m_axis_tuser, "data byte not flagged as data")

endmodule

### rtl/core/clr_frame_ram.sv
// Frame store: one write port, one registered read port, per-entry valid bits.
// Depends on clr_pkg.
module clr_frame_ram #(
  parameter int unsigned DEPTH = 2 * clr_pkg::CLR_COLUMNS,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clr_pkg::clr_ram_ctl_t ctl_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [7:0]            rdata_o
);
  import clr_pkg::*;

  logic [7:0]       mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [7:0]       rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= ctl_i.wdata;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Unwritten entries read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ctl_i.we) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.re) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : 8'h00;

endmodule

### bench/char_lcd_bus_checker.sv
// Checker for the character LCD line refresher: watches both streams, predicts
// the LCD bytes each command should produce and compares them in order.
// Depends on clr_pkg.
module char_lcd_bus_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import clr_pkg::*;

  localparam int unsigned COLUMNS = CLR_COLUMNS;

  typedef struct packed {
    logic       rs;
    logic [3:0] hi;
    logic [3:0] lo;
    logic       last;
  } lcd_byte_t;

  logic [7:0] pending_chars [2*COLUMNS];
  logic [7:0] shown_chars   [2*COLUMNS];
  lcd_byte_t  lcd_bytes_q[$];
  int         fails;

  function automatic lcd_byte_t lcd_byte(input logic rs, input logic [7:0] val);
    return '{rs: rs, hi: val[7:4], lo: val[3:0], last: 1'b0};
  endfunction

  // Model one command: update the frames and queue the bytes it sends.
  task automatic predict_lcd_bytes(input clr_cmd_e cmd, input logic ln,
                                   input logic [5:0] col, input logic [7:0] val);
    lcd_byte_t burst[$];
    lcd_byte_t b;
    int        base;
    logic      differs;
    case (cmd)
      CMD_WRITE: begin
        // columns past the line end are dropped
        if (int'(col) < COLUMNS) pending_chars[int'(ln) * COLUMNS + int'(col)] = val;
      end
      CMD_REFRESH: begin
        for (int l = 0; l < 2; l++) begin
          base    = l * COLUMNS;
          differs = 1'b0;
          for (int c = 0; c < COLUMNS; c++)
            if (pending_chars[base + c] != shown_chars[base + c]) differs = 1'b1;
          if (differs) begin
            burst.push_back(lcd_byte(1'b0, (l == 1) ? CLR_LINE1_ADDR : CLR_LINE0_ADDR));
            for (int c = 0; c < COLUMNS; c++) begin
              shown_chars[base + c] = pending_chars[base + c];
              burst.push_back(lcd_byte(1'b1, pending_chars[base + c]));
            end
          end
        end
      end
      CMD_POSITION: begin
        // no range check, only the 6-bit mask
        burst.push_back(lcd_byte(1'b0, (ln ? CLR_LINE1_ADDR : CLR_LINE0_ADDR)
                                       | {2'b00, col & CLR_COL_MASK}));
      end
      default: burst.push_back(lcd_byte(1'b0, val));
    endcase
    for (int i = 0; i < burst.size(); i++) begin
      b      = burst[i];
      b.last = (i == burst.size() - 1);
      lcd_bytes_q.push_back(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lcd_byte_t got;
    lcd_byte_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 2*COLUMNS; i++) begin
        pending_chars[i] = 8'h00;
        shown_chars[i]   = 8'h00;
      end
      lcd_bytes_q.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // output side first: a byte leaving now belongs to an earlier command
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{rs: m_axis_tuser, hi: m_axis_tdata[3:0], lo: m_axis_tdata[7:4],
                last: m_axis_tlast};
        if (lcd_bytes_q.size() == 0) begin
          $display("%0t: unexpected byte rs=%0b hi=%h lo=%h last=%0b",
                   $time, got.rs, got.hi, got.lo, got.last);
          fails++;
        end else begin
          want = lcd_bytes_q.pop_front();
          if (got.rs !== want.rs || got.hi !== want.hi || got.lo !== want.lo ||
              got.last !== want.last) begin
            $display({"%0t: byte mismatch exp rs=%0b hi=%h lo=%h last=%0b,",
                      " got rs=%0b hi=%h lo=%h last=%0b"},
                     $time, want.rs, want.hi, want.lo, want.last,
                     got.rs, got.hi, got.lo, got.last);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_lcd_bytes(clr_cmd_e'(s_axis_tuser), s_axis_tdata[0], s_axis_tdata[6:1],
                          s_axis_tdata[14:7]);
      fail_count_o <= fails;
      pending_o    <= lcd_bytes_q.size();
    end
  end

endmodule

### bench/tb.sv
// Top of the character LCD line refresher bench: clock, reset, command stimulus,
// sink with random stalls, and the verdict. Depends on clr_pkg,
// char_lcd_line_refresher_unit and char_lcd_bus_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import clr_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [0] line, [6:1] column, [14:7] byte_value, [15] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [3:0] high_nibble, [7:4] low_nibble
  logic        m_axis_tuser;        // [0] register_select
  logic        m_axis_tlast;

  int   fail_count;
  int   bytes_pending;
  logic idle_on = 1'b1;   // random gaps and stalls enabled
  int   cmds_sent;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  char_lcd_line_refresher_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  char_lcd_bus_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (bytes_pending)
  );

  // Offer one command and hold it until the transaction happens. Valid stays
  // high across back-to-back commands; it only drops for a real gap.
  task automatic send_cmd(input clr_cmd_e cmd, input logic ln, input logic [5:0] col,
                          input logic [7:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, val, col, ln};
    do @(posedge clk_i); while (!s_axis_tready);
    cmds_sent++;
  endtask

  // Sink: random stall per byte, plus one long hold-off so the block backs up
  // and drops s_axis_tready while the sender keeps offering.
  initial begin : lcd_sink
    int stall;
    int bytes_taken;
    bit held;
    bytes_taken = 0;
    held        = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && bytes_taken == 150) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      bytes_taken++;
    end
  end

  initial begin : run_limit
    #8ms;
    $display("char_lcd_line_refresher_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int pick;
    cmds_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: position and instruction extremes
    send_cmd(CMD_POSITION, 1'b0, 6'd0, 8'h00);
    send_cmd(CMD_POSITION, 1'b1, 6'd63, 8'hFF);   // column past the line end, masked only
    send_cmd(CMD_INSTR, 1'b0, 6'd0, 8'h00);
    send_cmd(CMD_INSTR, 1'b1, 6'd63, 8'hFF);
    // refresh right after reset: both frames zero, nothing sent
    send_cmd(CMD_REFRESH, 1'b0, 6'd0, 8'h00);
    send_cmd(CMD_WRITE, 1'b0, 6'd0, 8'hFF);
    send_cmd(CMD_WRITE, 1'b1, 6'd19, 8'hA5);
    send_cmd(CMD_WRITE, 1'b0, 6'd20, 8'h55);      // past the line end, dropped
    send_cmd(CMD_WRITE, 1'b1, 6'd63, 8'h33);      // dropped too
    send_cmd(CMD_REFRESH, 1'b1, 6'd63, 8'hFF);    // both lines
    send_cmd(CMD_REFRESH, 1'b0, 6'd0, 8'h00);     // no change
    send_cmd(CMD_WRITE, 1'b1, 6'd5, 8'h5A);
    send_cmd(CMD_REFRESH, 1'b0, 6'd0, 8'h00);     // second line only
    send_cmd(CMD_WRITE, 1'b0, 6'd0, 8'h00);
    send_cmd(CMD_REFRESH, 1'b0, 6'd0, 8'h00);     // first line only
    send_cmd(CMD_WRITE, 1'b0, 6'd3, 8'h00);       // same value as shown
    send_cmd(CMD_REFRESH, 1'b0, 6'd0, 8'h00);     // no change
    send_cmd(CMD_WRITE, 1'b0, 6'd19, 8'h80);
    send_cmd(CMD_WRITE, 1'b1, 6'd0, 8'h7F);
    send_cmd(CMD_REFRESH, 1'b0, 6'd0, 8'h00);

    // random: mostly bursts of writes closed by a refresh, some noise
    for (int n = 0; n < 110; n++) begin
      if (n == 60) idle_on = 1'b0;   // a stretch at full rate on both sides
      if (n == 90) idle_on = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        if ($urandom_range(0, 7) == 0)
          send_cmd(CMD_WRITE, 1'($urandom), 6'($urandom_range(20, 63)), 8'($urandom));
        else
          send_cmd(CMD_WRITE, 1'($urandom), 6'($urandom_range(0, 19)), 8'($urandom));
      end else if (pick == 7) begin
        send_cmd(CMD_POSITION, 1'($urandom), 6'($urandom), 8'($urandom));
      end else if (pick == 8) begin
        send_cmd(CMD_INSTR, 1'($urandom), 6'($urandom), 8'($urandom));
      end else begin
        send_cmd(CMD_REFRESH, 1'($urandom), 6'($urandom), 8'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    // let the checker's byte count catch up with the last transaction
    repeat (2) @(posedge clk_i);
    // drain, then keep watching for stray bytes
    while (bytes_pending != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("char_lcd_line_refresher_unit verification clean");
    end else begin
      $display("char_lcd_line_refresher_unit verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/clr_pkg.sv
rtl/core/clr_frame_ram.sv
rtl/core/char_lcd_line_refresher_unit.sv
bench/char_lcd_bus_checker.sv
bench/tb.sv
